FILE: rtl/pcs_pkg.sv
// pid controller step: shared types, widths and constants
// used by the channel interfaces and the top level
package pcs_pkg;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int SAMPLE_W = 32;
    localparam int TIME_W = 24;
    localparam int CNT_W = 7;

    localparam logic [CNT_W-1:0] MUL_LAST = 7'd3;
    localparam logic [CNT_W-1:0] MOD_LAST = 7'd33;
    localparam logic [CNT_W-1:0] DIV_LAST = 7'd63;

    localparam logic [46:0] BOUND_RESET = 47'h7FFF_FFFF_FFFF;
    localparam logic [63:0] D_CAP = 64'h4001_0000_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMOD,
        S_MULP,
        S_MULINC,
        S_MULI,
        S_DMOD,
        S_MULD,
        S_DIV,
        S_SUM,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_TARGET,
        REG_BOUND,
        REG_DRIVE_MIN,
        REG_DRIVE_MAX,
        REG_SPAN
    } t_reg_idx;

endpackage

FILE: rtl/pcs_if.sv
// valid/ready channels of the pid controller step block
// depends on pcs_pkg for field widths
interface pcs_in_if;
    import pcs_pkg::*;
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   step_time;
    modport source (output valid, opcode, sample, step_time, input ready);
    modport sink (input valid, opcode, sample, step_time, output ready);
endinterface

interface pcs_out_if;
    import pcs_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] drive;
    modport source (output valid, drive, input ready);
    modport sink (input valid, drive, output ready);
endinterface

FILE: rtl/pid_controller_step_top.sv
// pid controller step, derivative on measurement, with apb register file
// depends on pcs_pkg and the pcs_in_if / pcs_out_if channels
// a clear or a zero time step goes straight to the output; otherwise, in order: error wrap
//   (nonzero span), p, integral, i, then (not on first pass) delta wrap, d and divide
// one transaction at a time, the next accepted the cycle after the result leaves
// the 1 bit per cycle divider does the wraps and divide, the 48x8 multiplier the products
// synchronous active-low reset: registers to reset values, integral and history cleared
module pid_controller_step_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    pcs_in_if.sink                   i_in,
    pcs_out_if.source                o_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [pcs_pkg::ADDR_W-1:0] paddr,
    input  logic [pcs_pkg::DATA_W-1:0] pwdata,
    output logic [pcs_pkg::DATA_W-1:0] prdata,
    output logic                     pready
);
    import pcs_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    logic [31:0] r_gain_p, r_gain_i, r_gain_d, r_target, r_dmin, r_dmax;
    logic [46:0] r_bound;
    logic [30:0] r_span;

    logic [31:0]        r_meas, r_last, r_out;
    logic [23:0]        r_dt;
    logic               r_first;
    logic signed [32:0] r_err, r_dlt;
    logic signed [33:0] r_v;
    logic signed [47:0] r_accum;
    logic signed [63:0] r_p, r_i;
    logic [79:0]        r_prod;
    logic [31:0]        r_rem;
    logic [63:0]        r_quo;

    logic in_acc, cfg_wr, mul_done, mod_done, div_done;

    // register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (t_reg_idx'(paddr[5:3]))
            REG_GAIN_P:    prdata = {32'b0, r_gain_p};
            REG_GAIN_I:    prdata = {32'b0, r_gain_i};
            REG_GAIN_D:    prdata = {32'b0, r_gain_d};
            REG_TARGET:    prdata = {32'b0, r_target};
            REG_BOUND:     prdata = {17'b0, r_bound};
            REG_DRIVE_MIN: prdata = {32'b0, r_dmin};
            REG_DRIVE_MAX: prdata = {32'b0, r_dmax};
            REG_SPAN:      prdata = {33'b0, r_span};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_target <= '0;
            r_bound  <= BOUND_RESET;
            r_dmin   <= 32'h8000_0000;
            r_dmax   <= 32'h7FFF_FFFF;
            r_span   <= '0;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[5:3]))
                REG_GAIN_P:    r_gain_p <= pwdata[31:0];
                REG_GAIN_I:    r_gain_i <= pwdata[31:0];
                REG_GAIN_D:    r_gain_d <= pwdata[31:0];
                REG_TARGET:    r_target <= pwdata[31:0];
                REG_BOUND:     r_bound  <= pwdata[46:0];
                REG_DRIVE_MIN: r_dmin   <= pwdata[31:0];
                REG_DRIVE_MAX: r_dmax   <= pwdata[31:0];
                REG_SPAN:      r_span   <= pwdata[30:0];
                default:       r_span   <= r_span;
            endcase
        end
    end

    // magnitudes of signed operands
    logic [32:0] err_mag, dlt_mag;
    logic [47:0] acc_mag;
    logic [31:0] gp_mag, gi_mag, gd_mag;
    assign err_mag = r_err[32] ? 33'(-r_err) : r_err;
    assign dlt_mag = r_dlt[32] ? 33'(-r_dlt) : r_dlt;
    assign acc_mag = r_accum[47] ? 48'(-r_accum) : r_accum;
    assign gp_mag  = r_gain_p[31] ? 32'(-r_gain_p) : r_gain_p;
    assign gi_mag  = r_gain_i[31] ? 32'(-r_gain_i) : r_gain_i;
    assign gd_mag  = r_gain_d[31] ? 32'(-r_gain_d) : r_gain_d;

    // shared multiplier, one 8 bit digit of b per cycle, msb digit first
    logic [47:0] mul_a;
    logic [31:0] mul_b;
    logic [1:0]  dig_idx;
    logic [7:0]  dig;
    logic [55:0] part;
    logic [79:0] prod_next;
    logic        first_cyc;

    always_comb begin
        unique case (r_state)
            S_MULP: begin
                mul_a = {15'b0, err_mag};
                mul_b = gp_mag;
            end
            S_MULINC: begin
                mul_a = {15'b0, err_mag};
                mul_b = {8'b0, r_dt};
            end
            S_MULI: begin
                mul_a = acc_mag;
                mul_b = gi_mag;
            end
            default: begin
                mul_a = {15'b0, dlt_mag};
                mul_b = gd_mag;
            end
        endcase
    end

    // accumulators start from zero on the first cycle of each state
    assign first_cyc = r_cnt == '0;
    assign dig_idx   = 2'(2'd3 - r_cnt[1:0]);
    assign dig       = 8'(mul_b >> {dig_idx, 3'b000});
    assign part      = {8'b0, mul_a} * {48'b0, dig};
    assign prod_next = {(first_cyc ? 72'b0 : r_prod[71:0]), 8'h00} + {24'b0, part};

    // shared restoring divider, one quotient bit per cycle
    logic [31:0] dvs, rem_n;
    logic [32:0] dv_t, dv_diff;
    logic        dv_ge;
    logic [63:0] quo_n;
    assign dvs     = (r_state == S_DIV) ? {8'b0, r_dt} : {1'b0, r_span};
    assign dv_t    = {(first_cyc ? 32'b0 : r_rem), r_quo[63]};
    assign dv_diff = dv_t - {1'b0, dvs};
    assign dv_ge   = dv_t >= {1'b0, dvs};
    assign rem_n   = dv_ge ? dv_diff[31:0] : dv_t[31:0];
    assign quo_n   = {r_quo[62:0], dv_ge};

    // wrap into [-span/2, span/2)
    logic [29:0]        half;
    logic signed [32:0] x_e, x_d, w_res;
    logic signed [33:0] v_src;
    logic [33:0]        v_mag;
    logic [31:0]        w_m;
    assign half  = r_span[30:1];
    assign x_e   = $signed({r_target[31], r_target}) - $signed({i_in.sample[31], i_in.sample});
    assign x_d   = $signed({r_meas[31], r_meas}) - $signed({r_last[31], r_last});
    assign v_src = ((r_state == S_IDLE) ? {x_e[32], x_e} : {x_d[32], x_d})
                   + $signed({4'b0, half});
    assign v_mag = v_src[33] ? 34'(-v_src) : v_src;
    assign w_m   = (r_v[33] && rem_n != 32'd0) ? ({1'b0, r_span} - rem_n) : rem_n;
    assign w_res = $signed({1'b0, w_m}) - $signed({3'b000, half});

    // products and integral update
    logic [63:0]        pm, p_val, i_val;
    logic [41:0]        inc_mag;
    logic signed [49:0] inc50, acc_sum, lim50, acc_cl;
    assign pm      = prod_next[79:16];
    assign p_val   = (r_err[32] ^ r_gain_p[31]) ? 64'(-pm) : pm;
    assign i_val   = (r_accum[47] ^ r_gain_i[31]) ? 64'(-pm) : pm;
    assign inc_mag = prod_next[57:16];
    assign inc50   = r_err[32] ? -$signed({8'b0, inc_mag}) : $signed({8'b0, inc_mag});
    assign acc_sum = $signed({{2{r_accum[47]}}, r_accum}) + inc50;
    assign lim50   = $signed({3'b0, r_bound});
    always_comb begin
        priority if (acc_sum > lim50) begin
            acc_cl = lim50;
        end else if (acc_sum < -lim50) begin
            acc_cl = -lim50;
        end else begin
            acc_cl = acc_sum;
        end
    end

    // final sum, saturation and output clamp
    logic [63:0]        q_cap, d_val;
    logic signed [65:0] sum66;
    logic signed [31:0] sat32, lo32, out32;
    assign q_cap = (r_quo > D_CAP) ? D_CAP : r_quo;
    assign d_val = r_first ? 64'd0
                 : ((r_gain_d[31] == r_dlt[32]) ? 64'(-q_cap) : q_cap);
    assign sum66 = $signed({{2{r_p[63]}}, r_p}) + $signed({{2{r_i[63]}}, r_i})
                 + $signed({{2{d_val[63]}}, d_val});
    always_comb begin
        priority if (sum66 > 66'sh7FFF_FFFF) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (sum66 < -66'sh8000_0000) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = sum66[31:0];
        end
    end
    assign lo32  = (sat32 < $signed(r_dmin)) ? $signed(r_dmin) : sat32;
    assign out32 = (lo32 > $signed(r_dmax)) ? $signed(r_dmax) : lo32;

    // sequencer
    assign in_acc   = i_in.valid && i_in.ready;
    assign mul_done = r_cnt == MUL_LAST;
    assign mod_done = r_cnt == MOD_LAST;
    assign div_done = r_cnt == DIV_LAST;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (i_in.opcode || i_in.step_time == '0) begin
                        n_state = S_OUT;
                    end else if (r_span != '0) begin
                        n_state = S_EMOD;
                    end else begin
                        n_state = S_MULP;
                    end
                end
            end
            S_EMOD:   if (mod_done) n_state = S_MULP;
            S_MULP:   if (mul_done) n_state = S_MULINC;
            S_MULINC: if (mul_done) n_state = S_MULI;
            S_MULI: begin
                if (mul_done) begin
                    priority if (r_first) begin
                        n_state = S_SUM;
                    end else if (r_span != '0) begin
                        n_state = S_DMOD;
                    end else begin
                        n_state = S_MULD;
                    end
                end
            end
            S_DMOD:   if (mod_done) n_state = S_MULD;
            S_MULD:   if (mul_done) n_state = S_DIV;
            S_DIV:    if (div_done) n_state = S_SUM;
            S_SUM:    n_state = S_OUT;
            S_OUT:    if (o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = r_state == S_IDLE;
        o_out.valid = r_state == S_OUT;
        o_out.drive = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_accum <= '0;
            r_last  <= '0;
            r_first <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : CNT_W'(r_cnt + 1'b1);
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_meas <= i_in.sample;
                        r_dt   <= i_in.step_time;
                        r_out  <= '0;
                        r_v    <= v_src;
                        r_quo  <= {v_mag, 30'b0};
                        r_err  <= x_e;
                        if (i_in.opcode) begin
                            r_accum <= '0;
                            r_last  <= '0;
                            r_first <= 1'b1;
                        end
                    end
                end
                S_EMOD, S_DMOD: begin
                    r_rem <= rem_n;
                    r_quo <= quo_n;
                    if (mod_done) begin
                        if (r_state == S_EMOD) begin
                            r_err <= w_res;
                        end else begin
                            r_dlt <= w_res;
                        end
                    end
                end
                S_MULP: begin
                    r_prod <= prod_next;
                    if (mul_done) r_p <= p_val;
                end
                S_MULINC: begin
                    r_prod <= prod_next;
                    if (mul_done) r_accum <= acc_cl[47:0];
                end
                S_MULI: begin
                    r_prod <= prod_next;
                    if (mul_done) begin
                        r_i   <= i_val;
                        r_v   <= v_src;
                        r_quo <= {v_mag, 30'b0};
                        r_dlt <= x_d;
                    end
                end
                S_MULD: begin
                    r_prod <= prod_next;
                    if (mul_done) r_quo <= prod_next[63:0];
                end
                S_DIV: begin
                    r_rem <= rem_n;
                    r_quo <= quo_n;
                end
                S_SUM: begin
                    r_out   <= out32;
                    r_first <= 1'b0;
                    r_last  <= r_meas;
                end
                default: r_out <= r_out;
            endcase
        end
    end

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is pending");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.opcode |=> o_out.valid && o_out.drive == '0)
        else $error("clear transaction did not return zero");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= DIV_LAST))
        else $error("divider ran past its last step");

    a_first_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULI) && r_first && mul_done |=> r_state == S_SUM)
        else $error("derivative not skipped on first pass");

endmodule

FILE: test/tb_pcs_if.sv
// testbench view of the pid controller step channels
// nothing beyond the rtl interfaces in pcs_if.sv is needed; this file is kept empty of logic
`timescale 1ns / 100ps
package tb_pcs_types;
    typedef struct packed {
        logic        opcode;
        logic [31:0] sample;
        logic [23:0] step_time;
    } t_step_req;
endpackage

FILE: test/tb_top.sv
// testbench for pid_controller_step_top: apb register phases, random control steps
// an internal fixed-point pid predictor checks every drive value in order
`timescale 1ns / 100ps
module tb_top;
    import pcs_pkg::*;
    import tb_pcs_types::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    pcs_in_if  in_ch ();
    pcs_out_if out_ch ();

    pid_controller_step_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state and settings
    longint kp, ki, kd, setpt, ibound, dmin, dmax, span;
    longint integ, prev_meas;
    bit     no_history;

    t_step_req   step_queue[$];
    logic [31:0] drive_queue[$];
    int  send_idle_pct = 0, recv_stall_pct = 0, recv_hold = 0;
    int  errors = 0;
    bit  stim_done = 0;

    function automatic longint wrap_span(longint x);
        longint h, m;
        if (span == 0) return x;
        h = span / 2;
        m = (x + h) % span;
        if (m < 0) m += span;
        return m - h;
    endfunction

    function automatic longint mul_q16(longint a, longint b);
        longint ua, ub, r;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        r = ua * (ub >>> 16) + ((ua * (ub & 64'hFFFF)) >>> 16);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic logic [31:0] predict_drive(t_step_req s);
        longint meas, dt, err, p, i, d, sum, delta;
        logic [63:0] q;
        meas = longint'(signed'(s.sample));
        dt = longint'(s.step_time);
        d = 0;
        if (s.opcode) begin
            integ = 0; prev_meas = 0; no_history = 1;
            return 32'd0;
        end
        if (dt == 0) return 32'd0;
        err = wrap_span(setpt - meas);
        p = mul_q16(kp, err);
        integ += mul_q16(err, dt);
        if (integ > ibound) integ = ibound;
        if (integ < -ibound) integ = -ibound;
        i = mul_q16(ki, integ);
        if (!no_history) begin
            delta = wrap_span(meas - prev_meas);
            q = (64'(kd < 0 ? -kd : kd) * 64'(delta < 0 ? -delta : delta)) / 64'(dt);
            if (q > D_CAP) q = D_CAP;
            d = longint'(q);
            if ((kd < 0) == (delta < 0)) d = -d;
        end
        no_history = 0;
        prev_meas = meas;
        sum = p + i + d;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        if (sum < dmin) sum = dmin;
        if (sum > dmax) sum = dmax;
        return sum[31:0];
    endfunction

    // driver
    t_step_req cur;
    bit        in_taken = 1'b0;
    initial begin
        in_ch.valid = 1'b0; in_ch.opcode = 1'b0; in_ch.sample = '0; in_ch.step_time = '0;
    end
    always @(posedge i_clk) begin
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_taken) begin
            drive_queue.push_back(predict_drive(step_queue[0]));
            void'(step_queue.pop_front());
        end
    end
    always @(negedge i_clk) begin
        if (step_queue.size() > 0 && (in_ch.valid && !in_taken
                || $urandom_range(99) >= send_idle_pct)) begin
            cur = step_queue[0];
            in_ch.valid <= 1'b1;
            in_ch.opcode <= cur.opcode;
            in_ch.sample <= cur.sample;
            in_ch.step_time <= cur.step_time;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // receiver stall and monitor
    initial out_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (drive_queue.size() == 0) begin
                $error("unexpected transaction drive=%h", out_ch.drive);
                errors++;
            end else begin
                if (out_ch.drive !== drive_queue[0]) begin
                    $error("drive expected %h actual %h", drive_queue[0], out_ch.drive);
                    errors++;
                end
                void'(drive_queue.pop_front());
            end
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [63:0] v);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * idx); pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_GAIN_P:    kp = longint'(signed'(v[31:0]));
            REG_GAIN_I:    ki = longint'(signed'(v[31:0]));
            REG_GAIN_D:    kd = longint'(signed'(v[31:0]));
            REG_TARGET:    setpt = longint'(signed'(v[31:0]));
            REG_BOUND:     ibound = longint'(v[46:0]);
            REG_DRIVE_MIN: dmin = longint'(signed'(v[31:0]));
            REG_DRIVE_MAX: dmax = longint'(signed'(v[31:0]));
            REG_SPAN:      span = longint'(v[30:0]);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (step_queue.size() > 0 || in_ch.valid || drive_queue.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_val32();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(131072) - 65536;
            3: return $urandom_range(1 << 24) - (1 << 23);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_step_req rand_step();
        t_step_req s;
        s.opcode = ($urandom_range(39) == 0);
        s.sample = rand_val32();
        case ($urandom_range(7))
            0: s.step_time = 24'd0;
            1: s.step_time = 24'hFF_FFFF;
            2: s.step_time = 24'd1;
            default: s.step_time = 24'($urandom_range(4096));
        endcase
        if ($urandom_range(9) == 0) s.step_time = 24'($urandom);
        return s;
    endfunction

    task automatic push_step(logic op, logic [31:0] smp, logic [23:0] dt);
        t_step_req s;
        s.opcode = op; s.sample = smp; s.step_time = dt;
        step_queue.push_back(s);
    endtask

    task automatic rand_config(bit extremes);
        reg_write(REG_GAIN_P, extremes ? 64'(32'h8000_0000) : 64'(rand_val32()));
        reg_write(REG_GAIN_I, extremes ? 64'(32'h7FFF_FFFF) : 64'(rand_val32()));
        reg_write(REG_GAIN_D, extremes ? 64'(32'h8000_0000) : 64'(rand_val32()));
        reg_write(REG_TARGET, 64'(rand_val32()));
        reg_write(REG_BOUND, $urandom_range(2) == 0 ? 64'h7FFF_FFFF_FFFF
                  : {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF >> $urandom_range(30));
        reg_write(REG_DRIVE_MIN, 64'(rand_val32()));
        reg_write(REG_DRIVE_MAX, $urandom_range(1) ? 64'(32'h7FFF_FFFF) : 64'(rand_val32()));
        reg_write(REG_SPAN, $urandom_range(2) == 0 ? 64'd0
                  : ($urandom_range(3) == 0 ? 64'h7FFF_FFFF : 64'($urandom_range(1 << 22))));
    endtask

    initial begin
        kp = 0; ki = 0; kd = 0; setpt = 0; ibound = 64'h7FFF_FFFF_FFFF;
        dmin = -64'sd2147483648; dmax = 64'sd2147483647; span = 0;
        integ = 0; prev_meas = 0; no_history = 1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // directed: default registers, then nonzero gains
        push_step(1'b0, 32'h0001_0000, 24'h01_0000);
        push_step(1'b0, 32'h8000_0000, 24'hFF_FFFF);
        push_step(1'b0, 32'h7FFF_FFFF, 24'd1);
        wait_drained();
        reg_write(REG_GAIN_P, 64'h0002_0000);
        reg_write(REG_GAIN_I, 64'h0000_8000);
        reg_write(REG_GAIN_D, 64'hFFFF_0000);
        reg_write(REG_TARGET, 64'h0010_0000);
        reg_write(REG_BOUND, 64'h0000_0100_0000);
        reg_write(REG_DRIVE_MIN, 64'h7FFF_FFFF);
        reg_write(REG_DRIVE_MAX, 64'hFFF0_0000);
        reg_write(REG_SPAN, 64'h0100_0000);
        push_step(1'b0, 32'h0000_0000, 24'h00_8000);
        push_step(1'b0, 32'h8000_0000, 24'd0);
        push_step(1'b0, 32'h7FFF_FFFF, 24'hFF_FFFF);
        push_step(1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF);
        push_step(1'b0, 32'h00FF_0000, 24'd1);
        push_step(1'b0, 32'hFF00_0000, 24'd1);
        wait_drained();
        reg_write(REG_DRIVE_MIN, 64'(32'h8000_0000));
        reg_write(REG_DRIVE_MAX, 64'(32'h7FFF_FFFF));
        reg_write(REG_SPAN, 64'h7FFF_FFFF);
        reg_write(REG_BOUND, 64'd0);
        push_step(1'b0, 32'h8000_0000, 24'd1);
        push_step(1'b0, 32'h7FFF_FFFF, 24'd1);
        push_step(1'b0, 32'h1234_5678, 24'h00_0001);
        wait_drained();
        // random phases with differing idling
        for (int ph = 0; ph < 12; ph++) begin
            rand_config(ph == 11);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            if (ph == 2) recv_hold = 2000;
            for (int k = 0; k < 100; k++) step_queue.push_back(rand_step());
            wait_drained();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && drive_queue.size() == 0) begin
            $display("pid_controller_step_top: match");
        end else begin
            $display("pid_controller_step_top: mismatch");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("pid_controller_step_top: mismatch");
        $finish;
    end
endmodule
